### hdl/pffa_pkg.sv
// Shared constants, types and codes of the paged first-fit allocator.
`timescale 1ns / 1ps
package pffa_pkg;

  // Pool geometry
  localparam int PRIVATE_PAGES  = 64;
  localparam int SHARED_PAGES   = 4;
  localparam int PAGE_BYTES     = 4096;   // power of two: page and offset split by bits
  localparam int SLOTS_PER_PAGE = 128;
  localparam int ENTRY_HEADER   = 32;
  localparam int PAGE_HEADER    = 24;

  localparam int TOTAL_PAGES   = PRIVATE_PAGES + SHARED_PAGES;
  localparam int PAYLOAD_BYTES = PAGE_BYTES - PAGE_HEADER - ENTRY_HEADER;
  localparam int ALL_SLOTS     = TOTAL_PAGES * SLOTS_PER_PAGE;

  // Field widths
  localparam int MODE_W = 2;
  localparam int SIZE_W = 12;
  localparam int REQ_W  = 8;
  localparam int ADDR_W = 19;
  localparam int STAT_W = 2;

  localparam int PAGE_W = $clog2(TOTAL_PAGES);
  localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);
  localparam int LINK_W = SLOT_W + 1;
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int FREE_W = OFF_W + 1;
  localparam int SEG_AW = $clog2(ALL_SLOTS);

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PRIVATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHARED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // Classified request handed from the front end to the engine
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [REQ_W-1:0]  requester;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  page_off;
    logic              reject;
    logic [STAT_W-1:0] reject_status;
  } cmd_t;

endpackage

### hdl/pffa_front.sv
// Front end: takes requests and screens out bad sizes and bad free addresses.
`timescale 1ns / 1ps
module pffa_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pffa_pkg::MODE_W-1:0]   mode_i,
  input  logic [pffa_pkg::SIZE_W-1:0]   size_i,
  input  logic [pffa_pkg::REQ_W-1:0]    requester_i,
  input  logic [pffa_pkg::ADDR_W-1:0]   free_address_i,
  input  logic                          q_ready_i,
  output logic                          q_push_o,
  output pffa_pkg::cmd_t                q_cmd_o
);
  import pffa_pkg::*;

  logic [ADDR_W-OFF_W-1:0] addr_page;
  logic                    page_out;

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

  assign addr_page = free_address_i[ADDR_W-1:OFF_W];
  assign page_out  = 32'(addr_page) >= TOTAL_PAGES;

  // Classify the request
  always_comb begin
    q_cmd_o               = '0;
    q_cmd_o.mode          = mode_i;
    q_cmd_o.size          = size_i;
    q_cmd_o.requester     = requester_i;
    q_cmd_o.page          = PAGE_W'(addr_page);
    q_cmd_o.page_off      = free_address_i[OFF_W-1:0];
    q_cmd_o.reject        = 1'b0;
    q_cmd_o.reject_status = STAT_OK;
    if (mode_i == MODE_FREE) begin
      if (free_address_i == '0 || page_out) begin
        q_cmd_o.reject        = 1'b1;
        q_cmd_o.reject_status = STAT_NOT_FOUND;
      end
    end else if (mode_i != MODE_PRIVATE && mode_i != MODE_SHARED) begin
      q_cmd_o.reject        = 1'b1;
      q_cmd_o.reject_status = STAT_BAD_SIZE;
    end else if (size_i == '0 || 32'(size_i) > PAYLOAD_BYTES) begin
      q_cmd_o.reject        = 1'b1;
      q_cmd_o.reject_status = STAT_BAD_SIZE;
    end
  end

endmodule

### hdl/pffa_queue.sv
// Two-entry queue of classified requests between front end and engine.
`timescale 1ns / 1ps
module pffa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pffa_pkg::cmd_t cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           pop_i,
  output pffa_pkg::cmd_t cmd_o
);
  import pffa_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hdl/pffa_back.sv
// Engine: page tables, segment lists and the sequencer that serves requests.
`timescale 1ns / 1ps
module pffa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  pffa_pkg::cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pffa_pkg::STAT_W-1:0]   status_o,
  output logic [pffa_pkg::ADDR_W-1:0]   granted_address_o
);
  import pffa_pkg::*;

  typedef struct packed {
    logic              in_use;
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  length;
    logic              is_free;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } seg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  owner;
    logic              unclaimed;
    logic [FREE_W-1:0] free_bytes;
  } page_t;

  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOTS_PER_PAGE);
  localparam logic [LINK_W-1:0] LAST_CNT = LINK_W'(SLOTS_PER_PAGE);
  localparam logic [OFF_W-1:0]  EH = OFF_W'(ENTRY_HEADER);

  // Sequencer states
  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_PG_RD  = 5'd2;
  localparam logic [4:0] S_PG_CHK = 5'd3;
  localparam logic [4:0] S_SG_RD  = 5'd4;
  localparam logic [4:0] S_SG_CHK = 5'd5;
  localparam logic [4:0] S_FS_RD  = 5'd6;
  localparam logic [4:0] S_FS_CHK = 5'd7;
  localparam logic [4:0] S_WR_T   = 5'd8;
  localparam logic [4:0] S_NX_RD  = 5'd9;
  localparam logic [4:0] S_NX_WR  = 5'd10;
  localparam logic [4:0] S_WR_S   = 5'd11;
  localparam logic [4:0] S_FR_RD  = 5'd12;
  localparam logic [4:0] S_FR_CHK = 5'd13;
  localparam logic [4:0] S_FN_RD  = 5'd14;
  localparam logic [4:0] S_FN_CHK = 5'd15;
  localparam logic [4:0] S_FNN_RD = 5'd16;
  localparam logic [4:0] S_FNN_WR = 5'd17;
  localparam logic [4:0] S_FP     = 5'd18;
  localparam logic [4:0] S_FP_RD  = 5'd19;
  localparam logic [4:0] S_FP_CHK = 5'd20;
  localparam logic [4:0] S_FPN_RD = 5'd21;
  localparam logic [4:0] S_FPN_WR = 5'd22;
  localparam logic [4:0] S_WR_CUR = 5'd23;
  localparam logic [4:0] S_FR_PG  = 5'd24;
  localparam logic [4:0] S_DONE   = 5'd25;

  function automatic logic [SEG_AW-1:0] seg_index(logic [PAGE_W-1:0] p,
                                                  logic [SLOT_W-1:0] s);
    return SEG_AW'(32'(p) * SLOTS_PER_PAGE + 32'(s));
  endfunction

  // Memories
  seg_t  seg_mem [ALL_SLOTS];
  page_t pg_mem  [TOTAL_PAGES];
  seg_t  seg_rdata_q;
  page_t pg_rdata_q;

  logic              seg_we, pg_we;
  logic [SEG_AW-1:0] seg_wa, seg_ra;
  logic [PAGE_W-1:0] pg_wa, pg_ra;
  seg_t              seg_wd;
  page_t             pg_wd;

  // Control state
  logic [4:0]        state_q, state_d;
  logic [PAGE_W-1:0] clr_page_q, clr_page_d;
  logic [SLOT_W-1:0] clr_slot_q, clr_slot_d;
  logic              out_valid_q, out_valid_d;

  // Working registers
  cmd_t              cmd_q, cmd_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [LINK_W-1:0] slot_q, slot_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] tslot_q, tslot_d;
  logic [LINK_W-1:0] aux_q, aux_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  seg_t              cur_q, cur_d;
  page_t             pgw_q, pgw_d;
  logic              split_q, split_d;
  logic [FREE_W-1:0] gain_q, gain_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;

  logic              shared_req;
  logic              last_page;
  logic              page_ok;
  logic [OFF_W-1:0]  rest_rd, rest_cur;
  logic [LINK_W-1:0] cnt_inc;
  seg_t              seg_tmp;
  page_t             pg_tmp;

  assign shared_req = cmd_q.mode == MODE_SHARED;
  assign last_page  = shared_req ? (page_q == PAGE_W'(TOTAL_PAGES - 1))
                                 : (page_q == PAGE_W'(PRIVATE_PAGES - 1));
  assign page_ok    = (shared_req || pg_rdata_q.unclaimed ||
                       pg_rdata_q.owner == cmd_q.requester) &&
                      pg_rdata_q.free_bytes >= FREE_W'(cmd_q.size);
  assign rest_rd    = seg_rdata_q.length - cmd_q.size;
  assign rest_cur   = cur_q.length - cmd_q.size;
  assign cnt_inc    = cnt_q + LINK_W'(1);

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_page_d   = clr_page_q;
    clr_slot_d   = clr_slot_q;
    out_valid_d  = out_valid_q;
    cmd_d        = cmd_q;
    page_d       = page_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    tslot_d      = tslot_q;
    aux_d        = aux_q;
    cur_slot_d   = cur_slot_q;
    cur_d        = cur_q;
    pgw_d        = pgw_q;
    split_d      = split_q;
    gain_d       = gain_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    seg_we       = 1'b0;
    seg_wa       = '0;
    seg_wd       = '0;
    seg_ra       = '0;
    pg_we        = 1'b0;
    pg_wa        = '0;
    pg_wd        = '0;
    pg_ra        = '0;
    q_pop_o      = 1'b0;
    seg_tmp      = seg_rdata_q;
    pg_tmp       = pgw_q;

    // Drop a result the receiver has taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Sweep every slot to its reset image, one per cycle
      S_CLEAR: begin
        seg_we         = 1'b1;
        seg_wa         = seg_index(clr_page_q, clr_slot_q);
        seg_wd.in_use  = clr_slot_q == '0;
        seg_wd.offset  = OFF_W'(PAGE_HEADER);
        seg_wd.length  = OFF_W'(PAYLOAD_BYTES);
        seg_wd.is_free = 1'b1;
        seg_wd.next    = NO_SLOT;
        seg_wd.prev    = NO_SLOT;
        if (clr_slot_q == '0) begin
          pg_we            = 1'b1;
          pg_wa            = clr_page_q;
          pg_wd.owner      = '0;
          pg_wd.unclaimed  = 1'b1;
          pg_wd.free_bytes = FREE_W'(PAYLOAD_BYTES);
        end
        if (clr_slot_q == SLOT_W'(SLOTS_PER_PAGE - 1)) begin
          clr_slot_d = '0;
          if (clr_page_q == PAGE_W'(TOTAL_PAGES - 1)) begin
            state_d = S_IDLE;
          end else begin
            clr_page_d = clr_page_q + PAGE_W'(1);
          end
        end else begin
          clr_slot_d = clr_slot_q + SLOT_W'(1);
        end
      end

      // Take the next request
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          if (q_cmd_i.reject) begin
            res_status_d = q_cmd_i.reject_status;
            res_addr_d   = '0;
            state_d      = S_DONE;
          end else if (q_cmd_i.mode == MODE_FREE) begin
            page_d  = q_cmd_i.page;
            slot_d  = '0;
            state_d = S_FR_RD;
          end else begin
            page_d  = (q_cmd_i.mode == MODE_SHARED) ? PAGE_W'(PRIVATE_PAGES) : '0;
            state_d = S_PG_RD;
          end
        end
      end

      // Page scan
      S_PG_RD: begin
        pg_ra   = page_q;
        state_d = S_PG_CHK;
      end
      S_PG_CHK: begin
        pgw_d = pg_rdata_q;
        if (page_ok) begin
          slot_d  = '0;
          cnt_d   = '0;
          state_d = S_SG_RD;
        end else if (last_page) begin
          res_status_d = STAT_NO_SPACE;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else begin
          page_d  = page_q + PAGE_W'(1);
          state_d = S_PG_RD;
        end
      end

      // First-fit walk along the segment list
      S_SG_RD: begin
        seg_ra  = seg_index(page_q, slot_q[SLOT_W-1:0]);
        state_d = S_SG_CHK;
      end
      S_SG_CHK: begin
        if (seg_rdata_q.is_free && seg_rdata_q.length >= cmd_q.size) begin
          cur_d      = seg_rdata_q;
          cur_slot_d = slot_q[SLOT_W-1:0];
          split_d    = 1'b0;
          tslot_d    = LINK_W'(1);
          state_d    = (rest_rd > EH) ? S_FS_RD : S_WR_S;
        end else if (cnt_inc == LAST_CNT || seg_rdata_q.next >= NO_SLOT) begin
          if (last_page) begin
            res_status_d = STAT_NO_SPACE;
            res_addr_d   = '0;
            state_d      = S_DONE;
          end else begin
            page_d  = page_q + PAGE_W'(1);
            state_d = S_PG_RD;
          end
        end else begin
          slot_d  = seg_rdata_q.next;
          cnt_d   = cnt_inc;
          state_d = S_SG_RD;
        end
      end

      // Look for the lowest unused slot to hold the remainder
      S_FS_RD: begin
        seg_ra  = seg_index(page_q, tslot_q[SLOT_W-1:0]);
        state_d = S_FS_CHK;
      end
      S_FS_CHK: begin
        if (!seg_rdata_q.in_use) begin
          split_d = 1'b1;
          state_d = S_WR_T;
        end else if (tslot_q == LINK_W'(SLOTS_PER_PAGE - 1)) begin
          state_d = S_WR_S;
        end else begin
          tslot_d = tslot_q + LINK_W'(1);
          state_d = S_FS_RD;
        end
      end

      // Write the remainder segment and relink its successor
      S_WR_T: begin
        seg_we         = 1'b1;
        seg_wa         = seg_index(page_q, tslot_q[SLOT_W-1:0]);
        seg_wd.in_use  = 1'b1;
        seg_wd.offset  = cur_q.offset + EH + cmd_q.size;
        seg_wd.length  = rest_cur - EH;
        seg_wd.is_free = 1'b1;
        seg_wd.next    = cur_q.next;
        seg_wd.prev    = LINK_W'(cur_slot_q);
        state_d        = (cur_q.next < NO_SLOT) ? S_NX_RD : S_WR_S;
      end
      S_NX_RD: begin
        seg_ra  = seg_index(page_q, cur_q.next[SLOT_W-1:0]);
        state_d = S_NX_WR;
      end
      S_NX_WR: begin
        seg_tmp.prev = tslot_q;
        seg_we       = 1'b1;
        seg_wa       = seg_index(page_q, cur_q.next[SLOT_W-1:0]);
        seg_wd       = seg_tmp;
        state_d      = S_WR_S;
      end

      // Commit the granted segment and the page record
      S_WR_S: begin
        seg_tmp         = cur_q;
        seg_tmp.is_free = 1'b0;
        if (split_q) begin
          seg_tmp.next   = tslot_q;
          seg_tmp.length = cmd_q.size;
          pg_tmp.free_bytes = pgw_q.free_bytes - FREE_W'(cmd_q.size) -
                              FREE_W'(ENTRY_HEADER);
        end else begin
          pg_tmp.free_bytes = pgw_q.free_bytes - FREE_W'(cur_q.length);
        end
        pg_tmp.unclaimed = 1'b0;
        pg_tmp.owner     = shared_req ? '0 : cmd_q.requester;
        seg_we       = 1'b1;
        seg_wa       = seg_index(page_q, cur_slot_q);
        seg_wd       = seg_tmp;
        pg_we        = 1'b1;
        pg_wa        = page_q;
        pg_wd        = pg_tmp;
        res_status_d = STAT_OK;
        res_addr_d   = ADDR_W'(32'(page_q) * PAGE_BYTES + 32'(cur_q.offset) +
                               ENTRY_HEADER);
        state_d      = S_DONE;
      end

      // Free: find the allocated segment whose payload starts at the address
      S_FR_RD: begin
        seg_ra  = seg_index(page_q, slot_q[SLOT_W-1:0]);
        state_d = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (seg_rdata_q.in_use && !seg_rdata_q.is_free &&
            {1'b0, seg_rdata_q.offset} + FREE_W'(ENTRY_HEADER) == {1'b0, cmd_q.page_off}) begin
          cur_d         = seg_rdata_q;
          cur_d.is_free = 1'b1;
          cur_slot_d    = slot_q[SLOT_W-1:0];
          gain_d        = FREE_W'(seg_rdata_q.length);
          state_d       = (seg_rdata_q.next < NO_SLOT) ? S_FN_RD : S_FP;
        end else if (slot_q == LINK_W'(SLOTS_PER_PAGE - 1)) begin
          res_status_d = STAT_NOT_FOUND;
          res_addr_d   = '0;
          state_d      = S_DONE;
        end else begin
          slot_d  = slot_q + LINK_W'(1);
          state_d = S_FR_RD;
        end
      end

      // Absorb a free next neighbor
      S_FN_RD: begin
        seg_ra  = seg_index(page_q, cur_q.next[SLOT_W-1:0]);
        state_d = S_FN_CHK;
      end
      S_FN_CHK: begin
        if (seg_rdata_q.is_free) begin
          cur_d.length   = cur_q.length + EH + seg_rdata_q.length;
          cur_d.next     = seg_rdata_q.next;
          aux_d          = seg_rdata_q.next;
          gain_d         = gain_q + FREE_W'(ENTRY_HEADER);
          seg_tmp.in_use = 1'b0;
          seg_we         = 1'b1;
          seg_wa         = seg_index(page_q, cur_q.next[SLOT_W-1:0]);
          seg_wd         = seg_tmp;
          state_d        = (seg_rdata_q.next < NO_SLOT) ? S_FNN_RD : S_FP;
        end else begin
          state_d = S_FP;
        end
      end
      S_FNN_RD: begin
        seg_ra  = seg_index(page_q, aux_q[SLOT_W-1:0]);
        state_d = S_FNN_WR;
      end
      S_FNN_WR: begin
        seg_tmp.prev = LINK_W'(cur_slot_q);
        seg_we       = 1'b1;
        seg_wa       = seg_index(page_q, aux_q[SLOT_W-1:0]);
        seg_wd       = seg_tmp;
        state_d      = S_FP;
      end

      // Merge into a free previous neighbor
      S_FP: begin
        state_d = (cur_q.prev < NO_SLOT) ? S_FP_RD : S_WR_CUR;
      end
      S_FP_RD: begin
        seg_ra  = seg_index(page_q, cur_q.prev[SLOT_W-1:0]);
        state_d = S_FP_CHK;
      end
      S_FP_CHK: begin
        if (seg_rdata_q.is_free) begin
          seg_tmp.length = seg_rdata_q.length + EH + cur_q.length;
          seg_tmp.next   = cur_q.next;
          seg_we         = 1'b1;
          seg_wa         = seg_index(page_q, cur_q.prev[SLOT_W-1:0]);
          seg_wd         = seg_tmp;
          cur_d.in_use   = 1'b0;
          aux_d          = cur_q.next;
          gain_d         = gain_q + FREE_W'(ENTRY_HEADER);
          state_d        = (cur_q.next < NO_SLOT) ? S_FPN_RD : S_WR_CUR;
        end else begin
          state_d = S_WR_CUR;
        end
      end
      S_FPN_RD: begin
        seg_ra  = seg_index(page_q, aux_q[SLOT_W-1:0]);
        state_d = S_FPN_WR;
      end
      S_FPN_WR: begin
        seg_tmp.prev = cur_q.prev;
        seg_we       = 1'b1;
        seg_wa       = seg_index(page_q, aux_q[SLOT_W-1:0]);
        seg_wd       = seg_tmp;
        state_d      = S_WR_CUR;
      end

      // Write back the freed segment and credit the page
      S_WR_CUR: begin
        seg_we  = 1'b1;
        seg_wa  = seg_index(page_q, cur_slot_q);
        seg_wd  = cur_q;
        pg_ra   = page_q;
        state_d = S_FR_PG;
      end
      S_FR_PG: begin
        pg_tmp            = pg_rdata_q;
        pg_tmp.free_bytes = pg_rdata_q.free_bytes + gain_q;
        pg_we             = 1'b1;
        pg_wa             = page_q;
        pg_wd             = pg_tmp;
        res_status_d      = STAT_OK;
        res_addr_d        = '0;
        state_d           = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_page_q  <= '0;
      clr_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_page_q  <= clr_page_d;
      clr_slot_q  <= clr_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    page_q       <= page_d;
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    tslot_q      <= tslot_d;
    aux_q        <= aux_d;
    cur_slot_q   <= cur_slot_d;
    cur_q        <= cur_d;
    pgw_q        <= pgw_d;
    split_q      <= split_d;
    gain_q       <= gain_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  // Segment memory
  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    seg_rdata_q <= seg_mem[seg_ra];
  end

  // Page memory
  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_mem[pg_wa] <= pg_wd;
    end
    pg_rdata_q <= pg_mem[pg_ra];
  end

endmodule

### hdl/paged_first_fit_allocator.sv
// Top level of the paged first-fit allocator.
// Requests enter on the in channel (in_valid_i / in_ready_o) carrying mode_i,
// size_i, requester_i and free_address_i; each request yields exactly one
// transaction on the out channel (out_valid_o / out_ready_i) with status_o
// and granted_address_o, in request order.
// A front end screens sizes and free addresses and pushes each request into
// a two-entry queue; the engine serves one request at a time from the queue.
// An allocation visits page records, walks the segments of the chosen page
// and probes slots for the split remainder; a free probes up to 128 slots,
// then merges with free neighbors. All segment steps go through one read port
// of the segment memory, and page records through that of the page memory.
// Reset clears all control state; the engine then sweeps every slot of the
// segment memory to set every page to one free segment, and takes no request
// meanwhile (the queue still fills). A stalled receiver holds the result in
// the output register; the engine waits, and the queue keeps taking requests
// until full.
`timescale 1ns / 1ps
module paged_first_fit_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pffa_pkg::MODE_W-1:0]   mode_i,
  input  logic [pffa_pkg::SIZE_W-1:0]   size_i,
  input  logic [pffa_pkg::REQ_W-1:0]    requester_i,
  input  logic [pffa_pkg::ADDR_W-1:0]   free_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pffa_pkg::STAT_W-1:0]   status_o,
  output logic [pffa_pkg::ADDR_W-1:0]   granted_address_o
);
  import pffa_pkg::*;

  logic q_push, q_ready, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  pffa_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .size_i         (size_i),
    .requester_i    (requester_i),
    .free_address_i (free_address_i),
    .q_ready_i      (q_ready),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  pffa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd)
  );

  pffa_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .granted_address_o (granted_address_o)
  );

endmodule

### test/tb_paged_first_fit_allocator.sv
// Self-checking testbench of the paged first-fit allocator.
`timescale 1ns / 1ps
module tb_paged_first_fit_allocator;
  import pffa_pkg::*;

  localparam int NO_LINK   = SLOTS_PER_PAGE;
  localparam int CYC_LIMIT = 100000000;
  localparam int N_RANDOM  = 1600;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [SIZE_W-1:0]   size_i = '0;
  logic [REQ_W-1:0]    requester_i = '0;
  logic [ADDR_W-1:0]   free_address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [ADDR_W-1:0]   granted_address_o;

  paged_first_fit_allocator dut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] faddr;
    bit                typed;
    grant_t            want;
  } row_t;

  // Allocator image
  logic [REQ_W-1:0] own_q[TOTAL_PAGES];
  bit               unclaimed_q[TOTAL_PAGES];
  int               free_bytes_q[TOTAL_PAGES];
  bit               used_q[ALL_SLOTS];
  int               off_q[ALL_SLOTS];
  int               len_q[ALL_SLOTS];
  bit               isfree_q[ALL_SLOTS];
  int               nxt_q[ALL_SLOTS];
  int               prv_q[ALL_SLOTS];

  grant_t           pending_grants[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int               errors = 0;
  int               cycles = 0;
  bit               idle_on = 1'b1;
  bit               drain_quiet = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic void clear_image();
    for (int p = 0; p < TOTAL_PAGES; p++) begin
      own_q[p] = '0;
      unclaimed_q[p] = 1'b1;
      free_bytes_q[p] = PAYLOAD_BYTES;
      for (int s = 0; s < SLOTS_PER_PAGE; s++) used_q[p*SLOTS_PER_PAGE+s] = 1'b0;
      used_q[p*SLOTS_PER_PAGE] = 1'b1;
      off_q[p*SLOTS_PER_PAGE] = PAGE_HEADER;
      len_q[p*SLOTS_PER_PAGE] = PAYLOAD_BYTES;
      isfree_q[p*SLOTS_PER_PAGE] = 1'b1;
      nxt_q[p*SLOTS_PER_PAGE] = NO_LINK;
      prv_q[p*SLOTS_PER_PAGE] = NO_LINK;
    end
  endfunction

  // Grant slot s of page p; split off a free tail when it can hold a header
  function automatic int carve_segment(int p, int s, int size);
    int b, rest, t, nx;
    b = p * SLOTS_PER_PAGE;
    rest = len_q[b+s] - size;
    t = NO_LINK;
    if (rest > ENTRY_HEADER)
      for (int k = 1; k < SLOTS_PER_PAGE; k++)
        if (!used_q[b+k]) begin
          t = k;
          break;
        end
    if (t < NO_LINK) begin
      nx = nxt_q[b+s];
      used_q[b+t] = 1'b1;
      off_q[b+t] = off_q[b+s] + ENTRY_HEADER + size;
      len_q[b+t] = rest - ENTRY_HEADER;
      isfree_q[b+t] = 1'b1;
      prv_q[b+t] = s;
      nxt_q[b+t] = nx;
      if (nx < NO_LINK) prv_q[b+nx] = t;
      nxt_q[b+s] = t;
      len_q[b+s] = size;
      free_bytes_q[p] -= size + ENTRY_HEADER;
    end else begin
      free_bytes_q[p] -= len_q[b+s];
    end
    isfree_q[b+s] = 1'b0;
    return p * PAGE_BYTES + off_q[b+s] + ENTRY_HEADER;
  endfunction

  function automatic int fit_in_page(int p, int size);
    int b, s;
    b = p * SLOTS_PER_PAGE;
    s = 0;
    if (free_bytes_q[p] < size) return 0;
    for (int n = 0; n < SLOTS_PER_PAGE && s < NO_LINK; n++) begin
      if (isfree_q[b+s] && len_q[b+s] >= size) return carve_segment(p, s, size);
      s = nxt_q[b+s];
    end
    return 0;
  endfunction

  function automatic logic [STAT_W-1:0] release_block(int addr);
    int p, page_pos, b, s, gain, nx, pv, nn;
    if (addr == 0) return STAT_NOT_FOUND;
    p = addr / PAGE_BYTES;
    if (p >= TOTAL_PAGES) return STAT_NOT_FOUND;
    page_pos = addr % PAGE_BYTES;
    b = p * SLOTS_PER_PAGE;
    s = NO_LINK;
    for (int k = 0; k < SLOTS_PER_PAGE; k++)
      if (used_q[b+k] && !isfree_q[b+k] && off_q[b+k] + ENTRY_HEADER == page_pos) begin
        s = k;
        break;
      end
    if (s == NO_LINK) return STAT_NOT_FOUND;
    gain = len_q[b+s];
    isfree_q[b+s] = 1'b1;
    // absorb a free next neighbor
    nx = nxt_q[b+s];
    if (nx < NO_LINK && isfree_q[b+nx]) begin
      nn = nxt_q[b+nx];
      len_q[b+s] += ENTRY_HEADER + len_q[b+nx];
      nxt_q[b+s] = nn;
      if (nn < NO_LINK) prv_q[b+nn] = s;
      used_q[b+nx] = 1'b0;
      gain += ENTRY_HEADER;
    end
    // merge into a free previous neighbor
    pv = prv_q[b+s];
    if (pv < NO_LINK && isfree_q[b+pv]) begin
      nn = nxt_q[b+s];
      len_q[b+pv] += ENTRY_HEADER + len_q[b+s];
      nxt_q[b+pv] = nn;
      if (nn < NO_LINK) prv_q[b+nn] = pv;
      used_q[b+s] = 1'b0;
      gain += ENTRY_HEADER;
    end
    free_bytes_q[p] += gain;
    return STAT_OK;
  endfunction

  function automatic grant_t predict_grant(logic [MODE_W-1:0] mode, int size,
                                           logic [REQ_W-1:0] req, int faddr);
    grant_t g;
    int a;
    a = 0;
    g = '0;
    if (mode == MODE_FREE) begin
      g.status = release_block(faddr);
    end else if (mode != MODE_PRIVATE && mode != MODE_SHARED
                 || size == 0 || size > PAYLOAD_BYTES) begin
      g.status = STAT_BAD_SIZE;
    end else if (mode == MODE_PRIVATE) begin
      for (int p = 0; p < PRIVATE_PAGES && a == 0; p++)
        if (unclaimed_q[p] || own_q[p] == req) begin
          a = fit_in_page(p, size);
          if (a != 0 && unclaimed_q[p]) begin
            unclaimed_q[p] = 1'b0;
            own_q[p] = req;
          end
        end
      g.status = (a != 0) ? STAT_OK : STAT_NO_SPACE;
    end else begin
      for (int p = PRIVATE_PAGES; p < TOTAL_PAGES && a == 0; p++) begin
        a = fit_in_page(p, size);
        if (a != 0) begin
          unclaimed_q[p] = 1'b0;
          own_q[p] = '0;
        end
      end
      g.status = (a != 0) ? STAT_OK : STAT_NO_SPACE;
    end
    g.addr = a[ADDR_W-1:0];
    if (g.status == STAT_OK && mode != MODE_FREE) live_blocks.push_back(g.addr);
    return g;
  endfunction

  // Drive one transaction; typed rows are compared against the table too
  task automatic send_request(input row_t r);
    grant_t g;
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i <= r.mode;
    size_i <= r.size;
    requester_i <= r.req;
    free_address_i <= r.faddr;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    g = predict_grant(r.mode, int'(r.size), r.req, int'(r.faddr));
    if (r.typed && g != r.want)
      report($sformatf("table row mode %0d size %0d: predictor %h, table %h",
                       r.mode, r.size, g, r.want));
    pending_grants.push_back(r.typed ? r.want : g);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, sample at the rising edge
  always @(negedge clk_i)
    out_ready_i <= !(idle_on && $urandom_range(99) < 32);

  always @(posedge clk_i) begin
    grant_t e;
    cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        report("result with no expectation");
      end else begin
        e = pending_grants.pop_front();
        if (status_o !== e.status)
          report($sformatf("status %0d, expected %0d", status_o, e.status));
        if (granted_address_o !== e.addr)
          report($sformatf("address %0d, expected %0d", granted_address_o, e.addr));
      end
    end
    if (cycles > CYC_LIMIT) begin
      report("cycle limit reached");
      $display("tb_paged_first_fit_allocator: errors");
      $finish;
    end
  end

  function automatic row_t mk(logic [MODE_W-1:0] m, int sz, int rq, int fa,
                              bit typed, logic [STAT_W-1:0] st, int ad);
    row_t r;
    r.mode = m;
    r.size = SIZE_W'(sz);
    r.req = REQ_W'(rq);
    r.faddr = ADDR_W'(fa);
    r.typed = typed;
    r.want.status = st;
    r.want.addr = ADDR_W'(ad);
    return r;
  endfunction

  function automatic row_t random_row();
    int pick, sz;
    pick = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 600);
    if (pick < 50)
      return mk(MODE_PRIVATE, sz, $urandom_range(3) == 0 ? $urandom_range(255)
                : $urandom_range(3), 0, 0, STAT_OK, 0);
    if (pick < 62)
      return mk(MODE_SHARED, sz, $urandom_range(255), $urandom, 0, STAT_OK, 0);
    if (pick < 92 && live_blocks.size() > 0) begin
      int i;
      logic [ADDR_W-1:0] a;
      i = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[i];
      live_blocks.delete(i);
      return mk(MODE_FREE, $urandom, $urandom, int'(a), 0, STAT_OK, 0);
    end
    if (pick < 97) return mk(MODE_FREE, $urandom, $urandom, $urandom, 0, STAT_OK, 0);
    return mk(2'd3, $urandom, $urandom, $urandom, 0, STAT_OK, 0);
  endfunction

  initial begin
    row_t dir[$];
    int wait_cyc;
    clear_image();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: extremes, all modes, bad size, null free, merging
    dir.push_back(mk(MODE_PRIVATE, 0, 0, 0, 1, STAT_BAD_SIZE, 0));
    dir.push_back(mk(MODE_PRIVATE, PAYLOAD_BYTES + 1, 0, 0, 1, STAT_BAD_SIZE, 0));
    dir.push_back(mk(MODE_SHARED, 4095, 255, 0, 1, STAT_BAD_SIZE, 0));
    dir.push_back(mk(2'd3, 16, 1, 0, 1, STAT_BAD_SIZE, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, 0, 1, STAT_NOT_FOUND, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, 'h7FFFF, 1, STAT_NOT_FOUND, 0));
    dir.push_back(mk(MODE_PRIVATE, 1, 7, 0, 1, STAT_OK, PAGE_HEADER + ENTRY_HEADER));
    dir.push_back(mk(MODE_PRIVATE, 100, 7, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_PRIVATE, 200, 7, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_PRIVATE, 50, 255, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_PRIVATE, PAYLOAD_BYTES, 0, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_SHARED, PAYLOAD_BYTES, 255, 0, 1, STAT_OK,
                     PRIVATE_PAGES * PAGE_BYTES + PAGE_HEADER + ENTRY_HEADER));
    dir.push_back(mk(MODE_SHARED, PAYLOAD_BYTES - ENTRY_HEADER, 0, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_SHARED, 1, 3, 0, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, PAGE_HEADER + ENTRY_HEADER + 132, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, PAGE_HEADER + ENTRY_HEADER, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, PAGE_HEADER + ENTRY_HEADER, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, PAGE_HEADER + ENTRY_HEADER + 164, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, PRIVATE_PAGES * PAGE_BYTES + PAGE_HEADER
                     + ENTRY_HEADER, 0, STAT_OK, 0));
    dir.push_back(mk(MODE_FREE, 0, 0, TOTAL_PAGES * PAGE_BYTES, 1, STAT_NOT_FOUND, 0));
    foreach (dir[i]) send_request(dir[i]);

    // Random traffic; a stretch with no idle gaps or receiver stalls in the middle
    for (int n = 0; n < N_RANDOM; n++) begin
      idle_on = !(n >= 600 && n < 800);
      send_request(random_row());
    end
    idle_on = 1'b1;
    in_valid_i <= 1'b0;

    wait_cyc = 0;
    while (pending_grants.size() != 0 && wait_cyc < 400000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (400) @(posedge clk_i);
    if (pending_grants.size() != 0)
      report($sformatf("%0d results never arrived", pending_grants.size()));
    if (errors == 0)
      $display("tb_paged_first_fit_allocator: clean");
    else
      $display("tb_paged_first_fit_allocator: errors");
    $finish;
  end

endmodule

### filelist.f
hdl/pffa_pkg.sv
hdl/pffa_front.sv
hdl/pffa_queue.sv
hdl/pffa_back.sv
hdl/paged_first_fit_allocator.sv
test/tb_paged_first_fit_allocator.sv
